// ===== design/infix_to_postfix_converter_unit_defines.svh =====
// Assertion macros for the checker file itp_checker.sv.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define ITP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ITP_ASSERT_NEXT(lbl, cond, conseq, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== design/itp_pkg.sv =====
package itp_pkg;

   // characters of interest
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef logic [2:0] op_code_type;
   localparam op_code_type OP_TILDE = 3'd0;
   localparam op_code_type OP_CARET = 3'd1;
   localparam op_code_type OP_STAR  = 3'd2;
   localparam op_code_type OP_SLASH = 3'd3;
   localparam op_code_type OP_PLUS  = 3'd4;
   localparam op_code_type OP_MINUS = 3'd5;
   localparam op_code_type OP_OPEN  = 3'd6;

   typedef logic [1:0] err_type;
   localparam err_type ERR_NONE      = 2'd0;
   localparam err_type ERR_CHAR      = 2'd1;
   localparam err_type ERR_OVERFLOW  = 2'd2;
   localparam err_type ERR_UNMATCHED = 2'd3;

   typedef logic [6:0] score_type;
   localparam score_type SCORE_OPEN_IN = 7'd100;

   typedef struct packed {
      logic        valid;
      op_code_type code;
   } op_dec_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DEC, ST_CLASS, ST_LSP, ST_CLOSE, ST_OPPOP, ST_PUSH,
      ST_POPC, ST_POPS, ST_END, ST_ERR, ST_FIN
   } seq_state_type;

   typedef enum logic [1:0] {
      CMD_NONE, CMD_EMIT, CMD_FINISH
   } cmd_kind_type;

   typedef struct packed {
      logic       has;
      logic [7:0] chr;
      err_type    err;
   } res_type;

   typedef struct packed {
      cmd_kind_type kind;
      res_type      res;
      logic         last;
   } cmd_type;

   function automatic op_dec_type op_decode(input logic [7:0] c);
      op_dec_type d;
      d.valid = 1'b1;
      d.code  = OP_OPEN;
      unique case (c)
         CH_TILDE: d.code = OP_TILDE;
         CH_CARET: d.code = OP_CARET;
         CH_STAR:  d.code = OP_STAR;
         CH_SLASH: d.code = OP_SLASH;
         CH_PLUS:  d.code = OP_PLUS;
         CH_MINUS: d.code = OP_MINUS;
         CH_OPEN:  d.code = OP_OPEN;
         default:  d.valid = 1'b0;
      endcase
      return d;
   endfunction

   function automatic logic [7:0] op_char(input op_code_type code);
      logic [7:0] c;
      unique case (code)
         OP_TILDE: c = CH_TILDE;
         OP_CARET: c = CH_CARET;
         OP_STAR:  c = CH_STAR;
         OP_SLASH: c = CH_SLASH;
         OP_PLUS:  c = CH_PLUS;
         OP_MINUS: c = CH_MINUS;
         default:  c = CH_OPEN;
      endcase
      return c;
   endfunction

   function automatic score_type score_in(input op_code_type code);
      score_type s;
      unique case (code)
         OP_TILDE, OP_CARET: s = 7'd6;
         OP_STAR, OP_SLASH:  s = 7'd3;
         OP_PLUS, OP_MINUS:  s = 7'd1;
         default:            s = SCORE_OPEN_IN;
      endcase
      return s;
   endfunction

   function automatic score_type score_stack(input op_code_type code);
      score_type s;
      unique case (code)
         OP_TILDE, OP_CARET: s = 7'd5;
         OP_STAR, OP_SLASH:  s = 7'd4;
         OP_PLUS, OP_MINUS:  s = 7'd2;
         default:            s = 7'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== design/itp_ram.sv =====
module itp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== design/itp_out.sv =====
module itp_out (
   input  logic            clock,
   input  logic            reset,
   input  itp_pkg::cmd_type cmd,
   output logic            cmd_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_has_char,
   output logic [7:0]      rsp_out_char,
   output logic [1:0]      rsp_error,
   output logic            rsp_run_last,
   output logic            rsp_expr_end
);

   // one word is held back so that run_last can be set on the final one
   logic              pend_valid_ff, pend_valid_in;
   itp_pkg::res_type  pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   itp_pkg::res_type  res_ff, res_in;
   logic              run_last_ff, run_last_in;
   logic              expr_end_ff, expr_end_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.kind)
         itp_pkg::CMD_EMIT:   cmd_ready = !pend_valid_ff || out_free;
         itp_pkg::CMD_FINISH: cmd_ready = out_free;
         default:             cmd_ready = 1'b0;
      endcase
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      res_in        = res_ff;
      run_last_in   = run_last_ff;
      expr_end_in   = expr_end_ff;
      if (cmd.kind == itp_pkg::CMD_EMIT && cmd_ready) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            res_in       = pend_ff;
            run_last_in  = 1'b0;
            expr_end_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = cmd.res;
      end else if (cmd.kind == itp_pkg::CMD_FINISH && cmd_ready) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            res_in        = pend_ff;
            run_last_in   = 1'b1;
            expr_end_in   = cmd.last;
            pend_valid_in = 1'b0;
         end else if (cmd.last) begin
            // nothing came out of the last character: send a bare marker
            rsp_valid_in = 1'b1;
            res_in.has   = 1'b0;
            res_in.chr   = itp_pkg::CH_NUL;
            res_in.err   = itp_pkg::ERR_NONE;
            run_last_in  = 1'b1;
            expr_end_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff     <= pend_in;
      res_ff      <= res_in;
      run_last_ff <= run_last_in;
      expr_end_ff <= expr_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_has_char = res_ff.has;
   assign rsp_out_char = res_ff.chr;
   assign rsp_error    = res_ff.err;
   assign rsp_run_last = run_last_ff;
   assign rsp_expr_end = expr_end_ff;

endmodule

// ===== design/itp_seq.sv =====
module itp_seq #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_ch,
   input  logic                           req_last,
   output itp_pkg::cmd_type               cmd,
   input  logic                           cmd_ready,
   output logic                           we,
   output logic [$clog2(STACK_DEPTH)-1:0] waddr,
   output itp_pkg::op_code_type           wdata,
   output logic [$clog2(STACK_DEPTH)-1:0] raddr,
   input  itp_pkg::op_code_type           rdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] CNT_ONE   = CW'(1);

   itp_pkg::seq_state_type state_ff, state_in;
   itp_pkg::seq_state_type ret_ff, ret_in;
   logic [7:0]             ch_ff, ch_in;
   logic                   last_ff, last_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   in_number_ff, in_number_in;
   logic                   skip_ff, skip_in;
   itp_pkg::err_type       err_ff, err_in;
   logic                   fwd_hit_ff, fwd_hit_in;
   itp_pkg::op_code_type   fwd_data_ff;
   logic [CW-1:0]          top_idx;

   itp_pkg::op_dec_type    op;
   itp_pkg::op_code_type   top;
   itp_pkg::score_type     sc, ss;
   logic                   digit, letter, white, close_ch, empty, full;

   assign op       = itp_pkg::op_decode(ch_ff);
   assign digit    = ch_ff >= itp_pkg::CH_ZERO && ch_ff <= itp_pkg::CH_NINE;
   assign letter   = ch_ff >= itp_pkg::CH_LOW_A && ch_ff <= itp_pkg::CH_LOW_Z;
   assign white    = ch_ff == itp_pkg::CH_SPACE ||
                     (ch_ff >= itp_pkg::CH_TAB && ch_ff <= itp_pkg::CH_CR);
   assign close_ch = ch_ff == itp_pkg::CH_CLOSE;
   assign empty    = count_ff == '0;
   assign full     = count_ff >= DEPTH_CNT;

   // top of stack: the RAM always reads the entry below the next count,
   // with a bypass for a push that lands on that entry in the same cycle
   assign top      = fwd_hit_ff ? fwd_data_ff : rdata;
   assign top_idx  = count_in - CNT_ONE;
   assign raddr    = top_idx[AW-1:0];
   assign waddr    = count_ff[AW-1:0];
   assign wdata    = op.code;
   assign fwd_hit_in = we && (waddr == raddr);

   assign sc = itp_pkg::score_in(op.code);
   assign ss = itp_pkg::score_stack(top);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itp_pkg::ST_IDLE: begin
            if (req_valid) state_in = itp_pkg::ST_DEC;
         end
         itp_pkg::ST_DEC: begin
            if (skip_ff) begin
               state_in = itp_pkg::ST_FIN;
            end else if (in_number_ff && !digit) begin
               if (cmd_ready) state_in = itp_pkg::ST_CLASS;
            end else begin
               state_in = itp_pkg::ST_CLASS;
            end
         end
         itp_pkg::ST_CLASS: begin
            priority if (white) begin
               state_in = itp_pkg::ST_END;
            end else if (digit) begin
               if (cmd_ready) state_in = itp_pkg::ST_END;
            end else if (letter) begin
               if (cmd_ready) state_in = itp_pkg::ST_LSP;
            end else if (close_ch) begin
               state_in = itp_pkg::ST_CLOSE;
            end else if (op.valid) begin
               state_in = (empty || sc > ss) ? itp_pkg::ST_PUSH : itp_pkg::ST_OPPOP;
            end else begin
               state_in = itp_pkg::ST_ERR;
            end
         end
         itp_pkg::ST_LSP: begin
            if (cmd_ready) state_in = itp_pkg::ST_END;
         end
         itp_pkg::ST_CLOSE: begin
            priority if (empty) state_in = itp_pkg::ST_ERR;
            else if (top == itp_pkg::OP_OPEN) state_in = itp_pkg::ST_END;
            else state_in = itp_pkg::ST_POPC;
         end
         itp_pkg::ST_OPPOP: begin
            state_in = (!empty && sc < ss) ? itp_pkg::ST_POPC : itp_pkg::ST_PUSH;
         end
         itp_pkg::ST_PUSH: begin
            state_in = full ? itp_pkg::ST_ERR : itp_pkg::ST_END;
         end
         itp_pkg::ST_POPC: begin
            if (cmd_ready) state_in = itp_pkg::ST_POPS;
         end
         itp_pkg::ST_POPS: begin
            if (cmd_ready) state_in = ret_ff;
         end
         itp_pkg::ST_END: begin
            priority if (!last_ff) state_in = itp_pkg::ST_FIN;
            else if (in_number_ff) state_in = itp_pkg::ST_END;
            else if (!empty) state_in = itp_pkg::ST_POPC;
            else state_in = itp_pkg::ST_FIN;
         end
         itp_pkg::ST_ERR: begin
            if (cmd_ready) state_in = itp_pkg::ST_FIN;
         end
         itp_pkg::ST_FIN: begin
            if (cmd_ready) state_in = itp_pkg::ST_IDLE;
         end
         default: state_in = itp_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_ready    = 1'b0;
      cmd.kind     = itp_pkg::CMD_NONE;
      cmd.res.has  = 1'b1;
      cmd.res.chr  = itp_pkg::CH_SPACE;
      cmd.res.err  = itp_pkg::ERR_NONE;
      cmd.last     = last_ff;
      we           = 1'b0;
      ch_in        = ch_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      in_number_in = in_number_ff;
      skip_in      = skip_ff;
      ret_in       = ret_ff;
      err_in       = err_ff;
      unique case (state_ff)
         itp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ch_in   = req_ch;
               last_in = req_last;
            end
         end
         itp_pkg::ST_DEC: begin
            if (skip_ff) begin
               if (last_ff) begin
                  skip_in      = 1'b0;
                  count_in     = '0;
                  in_number_in = 1'b0;
               end
            end else if (in_number_ff && !digit) begin
               // close the digit run
               cmd.kind = itp_pkg::CMD_EMIT;
               if (cmd_ready) in_number_in = 1'b0;
            end
         end
         itp_pkg::ST_CLASS: begin
            priority if (white) begin
            end else if (digit) begin
               cmd.kind    = itp_pkg::CMD_EMIT;
               cmd.res.chr = ch_ff;
               if (cmd_ready) in_number_in = 1'b1;
            end else if (letter) begin
               cmd.kind    = itp_pkg::CMD_EMIT;
               cmd.res.chr = ch_ff;
            end else if (close_ch || op.valid) begin
            end else begin
               err_in = itp_pkg::ERR_CHAR;
            end
         end
         itp_pkg::ST_LSP: cmd.kind = itp_pkg::CMD_EMIT;
         itp_pkg::ST_CLOSE: begin
            priority if (empty) err_in = itp_pkg::ERR_UNMATCHED;
            else if (top == itp_pkg::OP_OPEN) count_in = count_ff - CNT_ONE;
            else ret_in = itp_pkg::ST_CLOSE;
         end
         itp_pkg::ST_OPPOP: begin
            ret_in = itp_pkg::ST_OPPOP;
         end
         itp_pkg::ST_PUSH: begin
            if (full) begin
               err_in = itp_pkg::ERR_OVERFLOW;
            end else begin
               we       = 1'b1;
               count_in = count_ff + CNT_ONE;
            end
         end
         itp_pkg::ST_POPC: begin
            cmd.kind    = itp_pkg::CMD_EMIT;
            cmd.res.chr = itp_pkg::op_char(top);
            if (cmd_ready) count_in = count_ff - CNT_ONE;
         end
         itp_pkg::ST_POPS: cmd.kind = itp_pkg::CMD_EMIT;
         itp_pkg::ST_END: begin
            ret_in = itp_pkg::ST_END;
            if (last_ff && in_number_ff) begin
               cmd.kind = itp_pkg::CMD_EMIT;
               if (cmd_ready) in_number_in = 1'b0;
            end
         end
         itp_pkg::ST_ERR: begin
            cmd.kind    = itp_pkg::CMD_EMIT;
            cmd.res.has = 1'b0;
            cmd.res.chr = itp_pkg::CH_NUL;
            cmd.res.err = err_ff;
            if (cmd_ready) begin
               count_in     = '0;
               in_number_in = 1'b0;
               skip_in      = !last_ff;
            end
         end
         itp_pkg::ST_FIN: cmd.kind = itp_pkg::CMD_FINISH;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itp_pkg::ST_IDLE;
         ret_ff       <= itp_pkg::ST_END;
         count_ff     <= '0;
         in_number_ff <= 1'b0;
         skip_ff      <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         count_ff     <= count_in;
         in_number_ff <= in_number_in;
         skip_ff      <= skip_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      fwd_data_ff <= wdata;
   end

endmodule

// ===== design/infix_to_postfix_converter_unit.sv =====
// Infix to postfix converter (shunting-yard), one character per input word.
// Input channel req_: req_ch is an ASCII character, req_last marks the end of
// the expression. Output channel rsp_: one postfix character per word, with
// rsp_has_char low for a bare marker or an error word (rsp_error non-zero),
// rsp_run_last on the final word caused by an input word and rsp_expr_end on
// the final word of the expression.
// Timing: an input word is taken only while the sequencer is idle. With no
// stack work a word goes through accept, decode, classify, wrap-up and
// finish before the next is taken; a word skipped after an error goes through
// accept, decode and finish. A letter's trailing space, a push, a matched
// close or a digit that ends the expression each add a step, a push that must
// first compare against the top adds a compare step, and each operator popped
// adds compare, operator and space steps. Each word waits in a one-word hold-back
// until the next word or the finish step, so that run_last can be set on the last.
// Reset clears the stack count, the digit-run and error-skip flags and both
// output stages; the stack memory itself needs no clearing pass.
// A stalled receiver (rsp_ready low) holds rsp_ words stable; the sequencer
// waits and req_ready stays low until the current word's results are queued.
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_has_char,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_error,
   output logic       rsp_run_last,
   output logic       rsp_expr_end
);

   localparam int AW = $clog2(STACK_DEPTH);

   itp_pkg::cmd_type     cmd;
   logic                 cmd_ready;
   logic                 we;
   logic [AW-1:0]        waddr, raddr;
   itp_pkg::op_code_type wdata, rdata;

   // operator stack storage
   itp_ram #(
      .WIDTH ($bits(itp_pkg::op_code_type)),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // sequencer: classify, push, pop and flush one step per cycle unless the output stage stalls it
   itp_seq #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .we        (we),
      .waddr     (waddr),
      .wdata     (wdata),
      .raddr     (raddr),
      .rdata     (rdata)
   );

   // hold-back stage and output register
   itp_out u_out (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cmd_ready    (cmd_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_has_char (rsp_has_char),
      .rsp_out_char (rsp_out_char),
      .rsp_error    (rsp_error),
      .rsp_run_last (rsp_run_last),
      .rsp_expr_end (rsp_expr_end)
   );

endmodule

// ===== design/itp_checker.sv =====
`include "infix_to_postfix_converter_unit_defines.svh"

module itp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_has_char,
   input logic [7:0] rsp_out_char,
   input logic [1:0] rsp_error,
   input logic       rsp_run_last,
   input logic       rsp_expr_end
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // a stalled word stays offered
   `ITP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")
   // the end of an expression is also the end of its input word
   `ITP_ASSERT(a_end_is_run_last, !(rsp_valid && rsp_expr_end) || rsp_run_last, "end no run")
   // a character word never carries an error
   `ITP_ASSERT(a_char_no_err, !(rsp_valid && rsp_has_char) || rsp_error == 2'd0, "char error")
   // markers and error words carry no character
   `ITP_ASSERT(a_marker_blank, !(rsp_valid && !rsp_has_char) || rsp_out_char == 8'd0, "marker char")
   // one input word at a time
   `ITP_ASSERT_NEXT(a_one_at_a_time, req_take, !req_ready, "ready right after accept")

endmodule

bind infix_to_postfix_converter_unit itp_checker u_chk (.*);

// ===== tb/sv/infix_to_postfix_converter_unit_test.sv =====
`timescale 1ns / 100ps

module infix_to_postfix_converter_unit_test;

   localparam int STACK_LIMIT = 16;

   // one postfix word as the block presents it on the rsp_ channel
   typedef struct packed {
      logic             has;
      logic [7:0]       chr;
      itp_pkg::err_type err;
      logic             run_last;
      logic             expr_end;
   } postfix_word_type;

   // one row of the directed stimulus; fixed rows carry their word typed in
   typedef struct {
      logic [7:0]       ch;
      logic             last;
      int               rep;
      bit               fixed;
      postfix_word_type word;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = itp_pkg::CH_NUL;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_has_char;
   logic [7:0] rsp_out_char;
   logic [1:0] rsp_error;
   logic       rsp_run_last;
   logic       rsp_expr_end;

   // shadow state of the converter
   itp_pkg::op_code_type opstack [STACK_LIMIT];
   int          op_depth = 0;
   bit          digit_run_open = 1'b0;
   bit          skip_to_end = 1'b0;

   postfix_word_type pending_words [$];
   postfix_word_type step_words [$];
   stim_row_type     directed_rows [$];

   int mismatch_count = 0;
   int words_seen = 0;
   int sent_items = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   infix_to_postfix_converter_unit #(
      .STACK_DEPTH(STACK_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_has_char(rsp_has_char),
      .rsp_out_char(rsp_out_char),
      .rsp_error(rsp_error),
      .rsp_run_last(rsp_run_last),
      .rsp_expr_end(rsp_expr_end)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Operator tables: incoming and in-stack precedence, and the glyph
   // ---------------------------------------------------------------------
   function automatic int in_rank(input itp_pkg::op_code_type code);
      case (code)
         itp_pkg::OP_TILDE, itp_pkg::OP_CARET: return 6;
         itp_pkg::OP_STAR, itp_pkg::OP_SLASH:  return 3;
         itp_pkg::OP_PLUS, itp_pkg::OP_MINUS:  return 1;
         default:                              return int'(itp_pkg::SCORE_OPEN_IN);
      endcase
   endfunction

   function automatic int stack_rank(input itp_pkg::op_code_type code);
      case (code)
         itp_pkg::OP_TILDE, itp_pkg::OP_CARET: return 5;
         itp_pkg::OP_STAR, itp_pkg::OP_SLASH:  return 4;
         itp_pkg::OP_PLUS, itp_pkg::OP_MINUS:  return 2;
         default:                              return 0;
      endcase
   endfunction

   function automatic logic [7:0] glyph_of(input itp_pkg::op_code_type code);
      case (code)
         itp_pkg::OP_TILDE: return itp_pkg::CH_TILDE;
         itp_pkg::OP_CARET: return itp_pkg::CH_CARET;
         itp_pkg::OP_STAR:  return itp_pkg::CH_STAR;
         itp_pkg::OP_SLASH: return itp_pkg::CH_SLASH;
         itp_pkg::OP_PLUS:  return itp_pkg::CH_PLUS;
         itp_pkg::OP_MINUS: return itp_pkg::CH_MINUS;
         default:           return itp_pkg::CH_OPEN;
      endcase
   endfunction

   // -1 for anything that is not a stackable operator
   function automatic int operator_index(input logic [7:0] c);
      case (c)
         itp_pkg::CH_TILDE: return int'(itp_pkg::OP_TILDE);
         itp_pkg::CH_CARET: return int'(itp_pkg::OP_CARET);
         itp_pkg::CH_STAR:  return int'(itp_pkg::OP_STAR);
         itp_pkg::CH_SLASH: return int'(itp_pkg::OP_SLASH);
         itp_pkg::CH_PLUS:  return int'(itp_pkg::OP_PLUS);
         itp_pkg::CH_MINUS: return int'(itp_pkg::OP_MINUS);
         itp_pkg::CH_OPEN:  return int'(itp_pkg::OP_OPEN);
         default:           return -1;
      endcase
   endfunction

   function automatic postfix_word_type marker_word(input itp_pkg::err_type e,
                                                    input logic fin);
      postfix_word_type w;
      w = '{has: 1'b0, chr: itp_pkg::CH_NUL, err: e, run_last: 1'b1, expr_end: fin};
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Postfix predictor: builds step_words for one accepted input word
   // ---------------------------------------------------------------------
   task automatic push_word(input logic has, input logic [7:0] chr,
                            input itp_pkg::err_type e);
      postfix_word_type w;
      w = '{has: has, chr: chr, err: e, run_last: 1'b0, expr_end: 1'b0};
      step_words.push_back(w);
   endtask

   // pop the top operator and emit it with its trailing space
   task automatic pop_operator();
      op_depth--;
      push_word(1'b1, glyph_of(opstack[op_depth]), itp_pkg::ERR_NONE);
      push_word(1'b1, itp_pkg::CH_SPACE, itp_pkg::ERR_NONE);
   endtask

   task automatic predict_postfix(input logic [7:0] c, input logic l);
      itp_pkg::err_type     e;
      bit                   is_digit;
      int                   idx;
      int                   rank;
      itp_pkg::op_code_type code;
      e = itp_pkg::ERR_NONE;
      is_digit = (c >= itp_pkg::CH_ZERO) && (c <= itp_pkg::CH_NINE);
      step_words.delete();

      if (skip_to_end) begin
         // swallow everything up to the end of the expression
         if (l) begin
            skip_to_end = 1'b0;
            op_depth = 0;
            digit_run_open = 1'b0;
         end
      end else begin
         // close a digit run on any non-digit
         if (digit_run_open && !is_digit) begin
            push_word(1'b1, itp_pkg::CH_SPACE, itp_pkg::ERR_NONE);
            digit_run_open = 1'b0;
         end
         if (c == itp_pkg::CH_SPACE || (c >= itp_pkg::CH_TAB && c <= itp_pkg::CH_CR)) begin
            // whitespace: drop
         end else if (is_digit) begin
            push_word(1'b1, c, itp_pkg::ERR_NONE);
            digit_run_open = 1'b1;
         end else if (c >= itp_pkg::CH_LOW_A && c <= itp_pkg::CH_LOW_Z) begin
            push_word(1'b1, c, itp_pkg::ERR_NONE);
            push_word(1'b1, itp_pkg::CH_SPACE, itp_pkg::ERR_NONE);
         end else if (c == itp_pkg::CH_CLOSE) begin
            while (op_depth > 0 && opstack[op_depth-1] != itp_pkg::OP_OPEN) pop_operator();
            if (op_depth == 0) e = itp_pkg::ERR_UNMATCHED;
            else op_depth--;
         end else begin
            idx = operator_index(c);
            if (idx < 0) begin
               e = itp_pkg::ERR_CHAR;
            end else begin
               code = itp_pkg::op_code_type'(idx);
               rank = in_rank(code);
               if (!(op_depth == 0 || rank > stack_rank(opstack[op_depth-1]))) begin
                  while (op_depth > 0 && rank < stack_rank(opstack[op_depth-1]))
                     pop_operator();
               end
               if (op_depth >= STACK_LIMIT) e = itp_pkg::ERR_OVERFLOW;
               else begin
                  opstack[op_depth] = code;
                  op_depth++;
               end
            end
         end

         if (e != itp_pkg::ERR_NONE) begin
            push_word(1'b0, itp_pkg::CH_NUL, e);
            op_depth = 0;
            digit_run_open = 1'b0;
            skip_to_end = !l;
         end else if (l) begin
            // flush: close the digit run, then empty the stack
            if (digit_run_open) begin
               push_word(1'b1, itp_pkg::CH_SPACE, itp_pkg::ERR_NONE);
               digit_run_open = 1'b0;
            end
            while (op_depth > 0) pop_operator();
         end
      end

      if (l && step_words.size() == 0) push_word(1'b0, itp_pkg::CH_NUL, itp_pkg::ERR_NONE);
      if (step_words.size() > 0) begin
         step_words[step_words.size()-1].run_last = 1'b1;
         step_words[step_words.size()-1].expr_end = l;
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: idle at random, then hold the word until req_ready takes it
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [7:0] c, input logic l, input bit fixed,
                            input postfix_word_type fixed_word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      predict_postfix(c, l);
      if (fixed) pending_words.push_back(fixed_word);
      else foreach (step_words[k]) pending_words.push_back(step_words[k]);
   endtask

   function automatic logic [7:0] random_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return itp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      if (r < 40) return itp_pkg::CH_LOW_A + 8'($urandom_range(0, 25));
      if (r < 70) return glyph_of(itp_pkg::op_code_type'($urandom_range(0, 6)));
      if (r < 80) return itp_pkg::CH_CLOSE;
      if (r < 86) return ($urandom_range(0, 1) == 0) ? itp_pkg::CH_SPACE
                           : itp_pkg::CH_TAB + 8'($urandom_range(0, 4));
      // noise: any byte at all
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly well-formed-ish expressions; now and then a deep run of
   // right-binding operators or open brackets to press the stack limit
   task automatic run_random_expressions(input int target);
      int         len;
      int         deep;
      logic [7:0] deep_ch;
      sent_items = 0;
      while (sent_items < target) begin
         len = $urandom_range(1, 10);
         if ($urandom_range(0, 9) == 0) begin
            deep = $urandom_range(12, 18);
            case ($urandom_range(0, 2))
               0:       deep_ch = itp_pkg::CH_OPEN;
               1:       deep_ch = itp_pkg::CH_CARET;
               default: deep_ch = itp_pkg::CH_TILDE;
            endcase
            repeat (deep) send_word(deep_ch, 1'b0, 1'b0, '0);
         end
         for (int k = 0; k < len; k++)
            send_word(random_char(), (k == len - 1), 1'b0, '0);
      end
   endtask

   function automatic stim_row_type plain_row(input logic [7:0] c, input logic l,
                                              input int rep);
      stim_row_type r;
      r.ch = c; r.last = l; r.rep = rep; r.fixed = 1'b0; r.word = '0;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(input logic [7:0] c, input logic l,
                                              input itp_pkg::err_type e);
      stim_row_type r;
      r.ch = c; r.last = l; r.rep = 1; r.fixed = 1'b1; r.word = marker_word(e, l);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (mismatch_count < 60) $display("mismatch @%0t word %0d: %s", $realtime, words_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // receiver: stall at random at the current rate
   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // take each rsp_ word and hold it against the oldest prediction
   always @(posedge clock) begin
      postfix_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word char %0h error %0d",
                                      rsp_out_char, rsp_error));
         end else begin
            want = pending_words.pop_front();
            check_field("has_char", rsp_has_char, want.has);
            check_field("out_char", rsp_out_char, want.chr);
            check_field("error",    rsp_error,    want.err);
            check_field("run_last", rsp_run_last, want.run_last);
            check_field("expr_end", rsp_expr_end, want.expr_end);
         end
         words_seen++;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      // empty end straight after reset
      directed_rows.push_back(fixed_row(itp_pkg::CH_SPACE, 1'b1, itp_pkg::ERR_NONE));
      // every operator and operand kind in one expression; CR closes a digit run
      directed_rows.push_back(plain_row(itp_pkg::CH_ZERO + 8'd7, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_CR, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_PLUS, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_LOW_A, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_STAR, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_OPEN, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_NINE, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_MINUS, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_TILDE, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_CARET, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_SLASH, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_LOW_Z, 1'b0, 1));
      directed_rows.push_back(plain_row(itp_pkg::CH_CLOSE, 1'b0, 1));
      // digit marked last: its space comes before the flush
      directed_rows.push_back(plain_row(itp_pkg::CH_ZERO + 8'd3, 1'b1, 1));
      // invalid characters at both ends of the byte range
      directed_rows.push_back(fixed_row(8'hFF, 1'b1, itp_pkg::ERR_CHAR));
      directed_rows.push_back(fixed_row(itp_pkg::CH_NUL, 1'b0, itp_pkg::ERR_CHAR));
      // skipped after the error, then a bare marker at the end
      directed_rows.push_back(plain_row(itp_pkg::CH_LOW_A, 1'b0, 1));
      directed_rows.push_back(fixed_row(itp_pkg::CH_ZERO, 1'b1, itp_pkg::ERR_NONE));
      // close bracket with nothing open
      directed_rows.push_back(fixed_row(itp_pkg::CH_CLOSE, 1'b1, itp_pkg::ERR_UNMATCHED));
      // fill the stack, then one push too many
      directed_rows.push_back(plain_row(itp_pkg::CH_OPEN, 1'b0, STACK_LIMIT));
      directed_rows.push_back(fixed_row(itp_pkg::CH_PLUS, 1'b1, itp_pkg::ERR_OVERFLOW));
      // open bracket left over at the flush is emitted
      directed_rows.push_back(plain_row(itp_pkg::CH_OPEN, 1'b1, 1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         repeat (directed_rows[i].rep)
            send_word(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].fixed, directed_rows[i].word);

      // random phases: no idling, sender idle, receiver stalling, both
      send_idle_pct = 0;  recv_stall_pct = 0;  run_random_expressions(60);
      send_idle_pct = 78; recv_stall_pct = 0;  run_random_expressions(60);
      send_idle_pct = 0;  recv_stall_pct = 78; run_random_expressions(60);
      send_idle_pct = 11; recv_stall_pct = 11; run_random_expressions(60);

      req_valid <= 1'b0;

      // drain, then give any stray word time to show up
      while (pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
